// ----- hw/rtl/uqsd_pkg.sv -----
// package for the url query string decoder
// holds the transaction item types, character and state codes and the hex digit decode
// no dependencies
package uqsd_pkg;

  localparam logic [7:0] CH_QUERY = 8'h3f;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] PH_PATH = 2'd0;
  localparam logic [1:0] PH_KEY0 = 2'd1;
  localparam logic [1:0] PH_VAL  = 2'd2;
  localparam logic [1:0] PH_KEY1 = 2'd3;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  localparam logic [1:0] PART_PATH  = 2'd0;
  localparam logic [1:0] PART_KEY   = 2'd1;
  localparam logic [1:0] PART_VALUE = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic [1:0] part;
    logic       path_done;
    logic       pair_done;
    logic       pair_kept;
    logic       done_res;
    logic       bad_escape;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b0;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h41 + 8'd10);
    end
    return h;
  endfunction

endpackage

// ----- hw/rtl/uqsd_byte_if.sv -----
// input channel of the url query string decoder: one raw target byte per transaction
// valid/ready handshake, no dependencies
interface uqsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source(output valid, in_byte, last, input ready);
  modport sink(input valid, in_byte, last, output ready);
endinterface

// ----- hw/rtl/uqsd_result_if.sv -----
// result channel of the url query string decoder: one decoded result per transaction
// valid/ready handshake, no dependencies
interface uqsd_result_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] data_byte;
  logic [1:0] part;
  logic       path_done;
  logic       pair_done;
  logic       pair_kept;
  logic       done_res;
  logic       bad_escape;

  modport source(output valid, has_byte, data_byte, part, path_done, pair_done, pair_kept,
                 done_res, bad_escape, input ready);
  modport sink(input valid, has_byte, data_byte, part, path_done, pair_done, pair_kept,
               done_res, bad_escape, output ready);
endinterface

// ----- hw/rtl/uqsd_core.sv -----
// parser state and single-pass decode of one held byte into at most one result
// depends on uqsd_pkg
module uqsd_core
  import uqsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t res,
  output logic      res_valid
);

  logic [1:0] phase, phase_next;
  logic [1:0] esc_step, esc_step_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       delim;
  logic       handled;
  hex_t       hex;
  logic [7:0] b;

  assign b   = item.in_byte;
  assign hex = hex_digit(b);

  always_comb begin
    res              = '0;
    phase_next       = phase;
    esc_step_next    = esc_step;
    high_nibble_next = high_nibble;
    handled          = 1'b0;
    delim            = (b == CH_AMP) || (b == CH_EQ && phase != PH_VAL);
    if (phase == PH_PATH) begin
      if (b == CH_QUERY) begin
        res.path_done = 1'b1;
        phase_next    = PH_KEY0;
      end else begin
        res.has_byte  = 1'b1;
        res.data_byte = b;
      end
    end else begin
      if (esc_step != ESC_NONE) begin
        if (delim) begin
          res.bad_escape = 1'b1;
          esc_step_next  = ESC_NONE;
        end else begin
          handled = 1'b1;
          if (!hex.ok) begin
            res.bad_escape = 1'b1;
            esc_step_next  = ESC_NONE;
          end else if (esc_step == ESC_HIGH) begin
            high_nibble_next = hex.value;
            esc_step_next    = ESC_LOW;
          end else begin
            res.has_byte  = 1'b1;
            res.data_byte = {high_nibble, hex.value};
            res.part      = (phase == PH_VAL) ? PART_VALUE : PART_KEY;
            esc_step_next = ESC_NONE;
          end
        end
      end
      if (!handled) begin
        if (b == CH_AMP) begin
          res.pair_done = 1'b1;
          res.pair_kept = (phase == PH_VAL);
          phase_next    = PH_KEY0;
        end else if (b == CH_EQ && phase != PH_VAL) begin
          phase_next = PH_VAL;
        end else begin
          if (phase == PH_KEY0) begin
            phase_next = PH_KEY1;
          end
          if (b == CH_PCT) begin
            esc_step_next = ESC_HIGH;
          end else begin
            res.has_byte  = 1'b1;
            res.data_byte = (b == CH_PLUS) ? CH_SPACE : b;
            res.part      = (phase == PH_VAL) ? PART_VALUE : PART_KEY;
          end
        end
      end
    end

    if (item.last) begin
      if (phase_next != PH_PATH) begin
        if (esc_step_next != ESC_NONE) begin
          res.bad_escape = 1'b1;
        end
        if (phase_next != PH_KEY0) begin
          res.pair_done = 1'b1;
          res.pair_kept = (phase_next == PH_VAL);
        end
      end
      res.done_res     = 1'b1;
      phase_next       = PH_PATH;
      esc_step_next    = ESC_NONE;
      high_nibble_next = 4'd0;
    end
  end

  assign res_valid = res.has_byte | res.path_done | res.pair_done | res.done_res |
                     res.bad_escape;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PATH;
      esc_step    <= ESC_NONE;
      high_nibble <= 4'd0;
    end else if (fire) begin
      phase       <= phase_next;
      esc_step    <= esc_step_next;
      high_nibble <= high_nibble_next;
    end
  end

  a_esc_only_in_query: assert property (@(posedge clk) disable iff (rst)
    esc_step != ESC_NONE |-> phase != PH_PATH)
    else $error("escape pending in path phase");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    fire && item.last |=> phase == PH_PATH && esc_step == ESC_NONE && high_nibble == 4'd0)
    else $error("state not cleared after last byte");

  a_part_tag: assert property (@(posedge clk) disable iff (rst)
    fire && res.has_byte && phase != PH_PATH |-> res.part != PART_PATH)
    else $error("query byte tagged as path");

  a_kept_needs_done: assert property (@(posedge clk) disable iff (rst)
    fire && res.pair_kept |-> res.pair_done && phase != PH_PATH)
    else $error("pair kept without pair end");

endmodule

// ----- hw/rtl/url_query_string_decoder.sv -----
// top level of the url query string decoder: input register, decode core, result register
// depends on uqsd_pkg, uqsd_byte_if, uqsd_result_if and uqsd_core
// The block takes one request target byte per transaction. It can accept a new byte in every
// cycle while results are taken as they come. The input stalls only while the result register
// holds a result that has not been taken. A byte waits in the input register until the core
// decodes it; any result is then registered in the result register and offered on the result
// channel until it is taken. Bytes before the first '?' come out
// raw as path bytes. After it, key and value bytes come out decoded ('+' to space, '%' and two
// hex digits to one byte) with their part tag. A pair ends on '&' or on the last byte, with a
// kept flag when an '=' was seen. A bad or truncated escape raises bad_escape. Bytes that
// produce nothing (the '=', a '%' or a high hex digit) give no result transaction. After the
// last byte the parser returns to the path phase.
module url_query_string_decoder
  import uqsd_pkg::*;
(
  input logic          clk,
  input logic          rst,
  uqsd_byte_if.sink    byte_ch,
  uqsd_result_if.source result_ch
);

  logic      in_valid;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      out_free;
  logic      fire;
  out_item_t res;
  logic      res_valid;

  assign out_free      = !out_valid || result_ch.ready;
  assign fire          = in_valid && out_free;
  assign byte_ch.ready = !in_valid || fire;

  uqsd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (in_item),
    .res       (res),
    .res_valid (res_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_ch.valid && byte_ch.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      in_item.in_byte <= byte_ch.in_byte;
      in_item.last    <= byte_ch.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_item <= res;
    end
  end

  assign result_ch.valid      = out_valid;
  assign result_ch.has_byte   = out_item.has_byte;
  assign result_ch.data_byte  = out_item.data_byte;
  assign result_ch.part       = out_item.part;
  assign result_ch.path_done  = out_item.path_done;
  assign result_ch.pair_done  = out_item.pair_done;
  assign result_ch.pair_kept  = out_item.pair_kept;
  assign result_ch.done_res   = out_item.done_res;
  assign result_ch.bad_escape = out_item.bad_escape;

endmodule
